// File: rtl/core/vtv_pkg.sv
// Shared types, codes and helpers for the vertex transform and viewport stage.
`timescale 1ns / 1ps
package vtv_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned OUT_TDATA_W = 96;
  localparam int unsigned DEPTH_MUL   = 2000;

  localparam logic signed [71:0] SAT_MAX = 72'sh7FFF_FFFF;
  localparam logic signed [71:0] SAT_MIN = -72'sh8000_0000;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_OFFSET_X     = 3'd2,
    CFG_OFFSET_Y     = 3'd3,
    CFG_DEPTH_SCALE  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        [15:0] half_w;
    logic        [15:0] half_h;
    logic signed [15:0] off_x;
    logic signed [15:0] off_y;
    logic signed [31:0] depth_scale;
  } view_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/vtv_xform.sv
// Coefficient table and two-stage 4x4 row-vector transform with saturation.
`timescale 1ns / 1ps
module vtv_xform #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_load_i,
  input  logic        [3:0]  coef_index_i,
  input  logic signed [31:0] coef_value_i,
  input  logic signed [31:0] vertex_x_i,
  input  logic signed [31:0] vertex_y_i,
  input  logic signed [31:0] vertex_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] x_o,
  output logic signed [31:0] y_o,
  output logic signed [31:0] z_o,
  output logic signed [31:0] w_o
);

  logic signed [31:0] coef_q [16];
  logic signed [31:0] vtx [3];
  logic signed [63:0] full [3][4];
  logic signed [63:0] prd_d [3][4];
  logic signed [63:0] prd_q [3][4];
  logic signed [31:0] bias_q [4];
  logic signed [65:0] acc [4];
  logic signed [31:0] sum_d [4];
  logic signed [31:0] sum_q [4];
  logic               va_q, vb_q;
  logic               adv_a, adv_b, take;

  assign adv_b      = !vb_q || out_ready_i;
  assign adv_a      = !va_q || adv_b;
  assign in_ready_o = adv_a;
  assign take       = in_valid_i && adv_a;

  assign vtx[0] = vertex_x_i;
  assign vtx[1] = vertex_y_i;
  assign vtx[2] = vertex_z_i;

  always_ff @(posedge clk_i) begin
    if (take && in_load_i) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  // Products use the table as it stands when the vertex beat is taken.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        full[r][c]  = vtx[r] * coef_q[r*4+c];
        prd_d[r][c] = full[r][c] >>> FRACTION_BITS;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc[c] = 66'(bias_q[c]) + 66'(prd_q[0][c]) + 66'(prd_q[1][c]) + 66'(prd_q[2][c]);
      sum_d[c] = vtv_pkg::sat32(72'(acc[c]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (adv_a) begin
        va_q <= in_valid_i && !in_load_i;
      end
      if (adv_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      prd_q <= prd_d;
      for (int c = 0; c < 4; c++) begin
        bias_q[c] <= coef_q[12+c];
      end
    end
    if (adv_b) begin
      sum_q <= sum_d;
    end
  end

  assign out_valid_o = vb_q;
  assign x_o = sum_q[0];
  assign y_o = sum_q[1];
  assign z_o = sum_q[2];
  assign w_o = sum_q[3];

endmodule

// File: rtl/core/vtv_div.sv
// Bit-per-stage restoring divider pipeline for the perspective divide, three lanes.
`timescale 1ns / 1ps
module vtv_div #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  input  logic signed [31:0] z_i,
  input  logic signed [31:0] w_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] x_o,
  output logic signed [31:0] y_o,
  output logic signed [31:0] z_o,
  output logic               wz_o
);

  localparam int unsigned NQ = 32 + FRACTION_BITS;

  typedef struct packed {
    logic [2:0][NQ-1:0] dvd;
    logic [2:0][NQ-1:0] quo;
    logic [2:0][31:0]   rem;
    logic [2:0][31:0]   orig;
    logic [31:0]        dvs;
    logic [2:0]         neg;
    logic               wz;
  } stage_t;

  stage_t             st_d [NQ+1];
  stage_t             st_q [NQ+1];
  logic [NQ+1:0]      vld_q;
  logic [NQ+2:0]      adv;
  logic signed [31:0] vin [3];
  logic signed [31:0] res_d [3];
  logic signed [31:0] res_q [3];
  logic               wz_q;

  assign vin[0] = x_i;
  assign vin[1] = y_i;
  assign vin[2] = z_i;

  always_comb begin
    adv[NQ+2] = out_ready_i;
    for (int i = NQ + 1; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end
  assign in_ready_o = adv[0];

  // Stage 0 splits signs and magnitudes; each later stage settles one quotient bit.
  always_comb begin
    logic [32:0] trial;
    logic        qb;
    logic [31:0] mag;
    st_d[0].dvs = w_i[31] ? 32'(~w_i + 32'sd1) : 32'(w_i);
    st_d[0].wz  = (w_i == 32'sd0);
    for (int l = 0; l < 3; l++) begin
      mag = vin[l][31] ? 32'(~vin[l] + 32'sd1) : 32'(vin[l]);
      st_d[0].dvd[l]  = NQ'(mag) << FRACTION_BITS;
      st_d[0].quo[l]  = '0;
      st_d[0].rem[l]  = '0;
      st_d[0].orig[l] = vin[l];
      st_d[0].neg[l]  = vin[l][31] ^ w_i[31];
    end
    for (int i = 1; i <= NQ; i++) begin
      st_d[i] = st_q[i-1];
      for (int l = 0; l < 3; l++) begin
        trial = {st_q[i-1].rem[l], st_q[i-1].dvd[l][NQ-1]};
        if (trial >= {1'b0, st_q[i-1].dvs}) begin
          trial = trial - {1'b0, st_q[i-1].dvs};
          qb = 1'b1;
        end else begin
          qb = 1'b0;
        end
        st_d[i].rem[l] = trial[31:0];
        st_d[i].dvd[l] = {st_q[i-1].dvd[l][NQ-2:0], 1'b0};
        st_d[i].quo[l] = {st_q[i-1].quo[l][NQ-2:0], qb};
      end
    end
  end

  always_comb begin
    logic [NQ-1:0] q;
    for (int l = 0; l < 3; l++) begin
      q = st_q[NQ].quo[l];
      if (st_q[NQ].wz) begin
        res_d[l] = st_q[NQ].orig[l];
      end else if (st_q[NQ].neg[l]) begin
        res_d[l] = (q > NQ'(32'h8000_0000)) ? 32'sh8000_0000 : 32'(~q[31:0] + 32'd1);
      end else begin
        res_d[l] = (q > NQ'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(q[31:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i <= NQ + 1; i++) begin
        if (adv[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i <= NQ; i++) begin
      if (adv[i]) begin
        st_q[i] <= st_d[i];
      end
    end
    if (adv[NQ+1]) begin
      res_q <= res_d;
      wz_q  <= st_q[NQ].wz;
    end
  end

  assign out_valid_o = vld_q[NQ+1];
  assign x_o  = res_q[0];
  assign y_o  = res_q[1];
  assign z_o  = res_q[2];
  assign wz_o = wz_q;

endmodule

// File: rtl/core/vtv_view.sv
// Viewport scaling and depth offset in two stages, the second being the output register.
`timescale 1ns / 1ps
module vtv_view #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vtv_pkg::view_cfg_t  cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  x_i,
  input  logic signed [31:0]  y_i,
  input  logic signed [31:0]  z_i,
  input  logic                wz_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  sx_o,
  output logic signed [31:0]  sy_o,
  output logic signed [31:0]  depth_o,
  output logic                wz_o
);

  localparam logic signed [32:0] ONE = 33'sd1 <<< FRACTION_BITS;

  logic               v1_q, v2_q, adv1, adv2;
  logic signed [32:0] xe, ye;
  logic signed [49:0] px_q, py_q;
  logic signed [43:0] pd_q;
  logic signed [31:0] z1_q;
  logic               wz1_q;
  logic signed [71:0] offx, offy, sx_w, sy_w, d_w;
  logic signed [31:0] sx_q, sy_q, d_q;
  logic               wz2_q;

  assign adv2       = !v2_q || out_ready_i;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  assign xe = 33'(x_i) + ONE;
  assign ye = 33'(y_i) + ONE;

  assign offx = 72'(cfg_i.off_x) <<< FRACTION_BITS;
  assign offy = 72'(cfg_i.off_y) <<< FRACTION_BITS;
  assign sx_w = 72'(px_q) + offx;
  assign sy_w = 72'(py_q) + offy;
  assign d_w  = 72'(z1_q) - 72'(pd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      px_q  <= xe * $signed({1'b0, cfg_i.half_w});
      py_q  <= ye * $signed({1'b0, cfg_i.half_h});
      pd_q  <= cfg_i.depth_scale * $signed(12'(vtv_pkg::DEPTH_MUL));
      z1_q  <= z_i;
      wz1_q <= wz_i;
    end
    if (adv2) begin
      sx_q  <= vtv_pkg::sat32(sx_w);
      sy_q  <= vtv_pkg::sat32(sy_w);
      d_q   <= vtv_pkg::sat32(d_w);
      wz2_q <= wz1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign sx_o    = sx_q;
  assign sy_o    = sy_q;
  assign depth_o = d_q;
  assign wz_o    = wz2_q;

endmodule

// File: rtl/core/vertex_transform_viewport.sv
// Throughput: one beat per cycle unless back-pressure on m_axis_tready_i stalls it;
// the restoring divider settles one quotient bit per stage for all three coordinates,
// so its 32 + FRACTION_BITS stages set the depth.
// Load beats write the coefficient table and produce no result.
// Reset clears pipeline valid bits and presets config registers; table is not reset.
`timescale 1ns / 1ps
module vertex_transform_viewport #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // coef_index[3:0], coef_value[35:4], vertex_x[67:36], vertex_y[99:68],
  // vertex_z[131:100], zero pad[135:132]
  input  logic [135:0] s_axis_tdata_i,
  // command[0]
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // screen_x[31:0], screen_y[63:32], depth[95:64]
  output logic [95:0]  m_axis_tdata_o,
  // w_was_zero[0]
  output logic         m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic [15:0]        width_q, height_q;
  logic signed [15:0] offx_q, offy_q;
  logic signed [31:0] dscale_q;
  vtv_pkg::view_cfg_t vcfg;

  logic               xf_valid, xf_ready;
  logic signed [31:0] xf_x, xf_y, xf_z, xf_w;
  logic               dv_valid, dv_ready, dv_wz;
  logic signed [31:0] dv_x, dv_y, dv_z;
  logic signed [31:0] sx, sy, dep;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 16'd1920;
      height_q <= 16'd1080;
      offx_q   <= '0;
      offy_q   <= '0;
      dscale_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        vtv_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[15:0];
        vtv_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[15:0];
        vtv_pkg::CFG_OFFSET_X:     offx_q   <= cfg_data_i[15:0];
        vtv_pkg::CFG_OFFSET_Y:     offy_q   <= cfg_data_i[15:0];
        vtv_pkg::CFG_DEPTH_SCALE:  dscale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign vcfg.half_w      = width_q >> 1;
  assign vcfg.half_h      = height_q >> 1;
  assign vcfg.off_x       = offx_q;
  assign vcfg.off_y       = offy_q;
  assign vcfg.depth_scale = dscale_q;

  vtv_xform #(.FRACTION_BITS(FRACTION_BITS)) u_xform (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_load_i    (s_axis_tuser_i == vtv_pkg::CMD_LOAD),
    .coef_index_i (s_axis_tdata_i[3:0]),
    .coef_value_i (s_axis_tdata_i[35:4]),
    .vertex_x_i   (s_axis_tdata_i[67:36]),
    .vertex_y_i   (s_axis_tdata_i[99:68]),
    .vertex_z_i   (s_axis_tdata_i[131:100]),
    .out_valid_o  (xf_valid),
    .out_ready_i  (xf_ready),
    .x_o          (xf_x),
    .y_o          (xf_y),
    .z_o          (xf_z),
    .w_o          (xf_w)
  );

  vtv_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (xf_valid),
    .in_ready_o  (xf_ready),
    .x_i         (xf_x),
    .y_i         (xf_y),
    .z_i         (xf_z),
    .w_i         (xf_w),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .x_o         (dv_x),
    .y_o         (dv_y),
    .z_o         (dv_z),
    .wz_o        (dv_wz)
  );

  vtv_view #(.FRACTION_BITS(FRACTION_BITS)) u_view (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (vcfg),
    .in_valid_i  (dv_valid),
    .in_ready_o  (dv_ready),
    .x_i         (dv_x),
    .y_i         (dv_y),
    .z_i         (dv_z),
    .wz_i        (dv_wz),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sx_o        (sx),
    .sy_o        (sy),
    .depth_o     (dep),
    .wz_o        (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {dep, sy, sx};

endmodule

// File: dv/vertex_transform_viewport_tb.sv
// Self-checking regression for the vertex transform and viewport stage.
`timescale 1ns / 1ps
module vertex_transform_viewport_tb;

  localparam int unsigned FB         = 16;
  localparam int unsigned DRAIN_WAIT = 100;
  localparam longint      CYCLE_CAP  = 1000000;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] d;
    logic               wz;
  } screen_point_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [135:0] s_axis_tdata_i;
  logic         s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [95:0]  m_axis_tdata_o;
  logic         m_axis_tuser_o;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [31:0]  cfg_data_i;

  vertex_transform_viewport #(.FRACTION_BITS(FB)) uut (.*);

  // Predictor state: the matrix and the viewport settings as last written.
  logic signed [31:0] matrix_q [16];
  longint             half_w_q, half_h_q, off_x_q, off_y_q, dscale_q;
  screen_point_t      pending_points[$];
  int                 mismatches;
  int                 vertices_sent, loads_sent, cfg_writes, points_checked;
  longint             cycle_count;
  bit                 calm;  // when set, neither side inserts idle cycles

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint column_dot(input longint vx, input longint vy,
                                        input longint vz, input int c);
    longint acc;
    acc = longint'(matrix_q[12 + c]);
    acc += (vx * longint'(matrix_q[c])) >>> FB;
    acc += (vy * longint'(matrix_q[4 + c])) >>> FB;
    acc += (vz * longint'(matrix_q[8 + c])) >>> FB;
    return clamp32(acc);
  endfunction

  function automatic screen_point_t project_vertex(input logic signed [31:0] vx,
                                                   input logic signed [31:0] vy,
                                                   input logic signed [31:0] vz);
    screen_point_t p;
    longint        x, y, z, w, one;
    one = longint'(1) <<< FB;
    x = column_dot(longint'(vx), longint'(vy), longint'(vz), 0);
    y = column_dot(longint'(vx), longint'(vy), longint'(vz), 1);
    z = column_dot(longint'(vx), longint'(vy), longint'(vz), 2);
    w = column_dot(longint'(vx), longint'(vy), longint'(vz), 3);
    p.wz = (w == 0);
    if (!p.wz) begin
      x = clamp32((x * one) / w);
      y = clamp32((y * one) / w);
      z = clamp32((z * one) / w);
    end
    p.sx = 32'(clamp32((x + one) * half_w_q + off_x_q * one));
    p.sy = 32'(clamp32((y + one) * half_h_q + off_y_q * one));
    p.d  = 32'(clamp32(z - dscale_q * 2000));
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return $urandom;
      2: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h (point %0d)", what, got, want,
             points_checked);
    mismatches++;
  endtask

  // One beat on the input stream; the prediction is made at acceptance.
  task automatic send_beat(input vtv_pkg::cmd_e cmd, input logic [3:0] idx,
                           input logic [31:0] coef, input logic [31:0] vx,
                           input logic [31:0] vy, input logic [31:0] vz);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {4'b0, vz, vy, vx, coef, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (cmd == vtv_pkg::CMD_LOAD) begin
      matrix_q[idx] = coef;
      loads_sent++;
    end else begin
      pending_points.push_back(project_vertex(vx, vy, vz));
      vertices_sent++;
    end
  endtask

  task automatic load_coef(input int idx, input logic [31:0] v);
    send_beat(vtv_pkg::CMD_LOAD, 4'(idx), v, $urandom, $urandom, $urandom);
  endtask

  task automatic send_vertex(input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] vz);
    send_beat(vtv_pkg::CMD_XFORM, 4'($urandom), $urandom, vx, vy, vz);
  endtask

  // Writes happen only once the pipeline has emptied, loads included.
  task automatic write_cfg(input logic [2:0] idx, input logic [31:0] v);
    s_axis_tvalid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    case (idx)
      vtv_pkg::CFG_IMAGE_WIDTH:  half_w_q = longint'(v[15:0] / 2);
      vtv_pkg::CFG_IMAGE_HEIGHT: half_h_q = longint'(v[15:0] / 2);
      vtv_pkg::CFG_OFFSET_X:     off_x_q  = longint'($signed(v[15:0]));
      vtv_pkg::CFG_OFFSET_Y:     off_y_q  = longint'($signed(v[15:0]));
      vtv_pkg::CFG_DEPTH_SCALE:  dscale_q = longint'($signed(v));
      default: ;
    endcase
  endtask

  task automatic set_view(input logic [15:0] wd, input logic [15:0] ht,
                          input logic [15:0] ox, input logic [15:0] oy,
                          input logic [31:0] ds);
    write_cfg(vtv_pkg::CFG_IMAGE_WIDTH, {16'($urandom), wd});
    write_cfg(vtv_pkg::CFG_IMAGE_HEIGHT, {16'($urandom), ht});
    write_cfg(vtv_pkg::CFG_OFFSET_X, {16'($urandom), ox});
    write_cfg(vtv_pkg::CFG_OFFSET_Y, {16'($urandom), oy});
    write_cfg(vtv_pkg::CFG_DEPTH_SCALE, ds);
  endtask

  task automatic load_matrix(input bit flat_w);
    for (int i = 0; i < 16; i++) begin
      if (flat_w && (i % 4 == 3)) load_coef(i, 32'h0);
      else load_coef(i, rand_word());
    end
  endtask

  // Result side: random back-pressure and an in-order comparison.
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    screen_point_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_points.size() == 0) begin
          report_mismatch("result beat with no vertex outstanding",
                          m_axis_tdata_o[31:0], 32'h0);
        end else begin
          want = pending_points.pop_front();
          if (m_axis_tdata_o[31:0] !== want.sx)
            report_mismatch("screen_x", m_axis_tdata_o[31:0], want.sx);
          if (m_axis_tdata_o[63:32] !== want.sy)
            report_mismatch("screen_y", m_axis_tdata_o[63:32], want.sy);
          if (m_axis_tdata_o[95:64] !== want.d)
            report_mismatch("depth", m_axis_tdata_o[95:64], want.d);
          if (m_axis_tuser_o !== want.wz)
            report_mismatch("w_was_zero", 32'(m_axis_tuser_o), 32'(want.wz));
          points_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        stall_left = pick_gap();
        m_axis_tready_i <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d points outstanding", cycle_count,
               pending_points.size());
      $display("vertex_transform_viewport regression: fail");
      $finish;
    end
  end

  task automatic test_identity();
    for (int i = 0; i < 16; i++)
      load_coef(i, (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
    send_vertex(32'h0, 32'h0, 32'h0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
    send_vertex(32'hFFFF_FFFF, 32'h0000_8000, 32'h8000_0000);
  endtask

  task automatic test_zero_w();
    load_coef(3, 32'h0);
    load_coef(7, 32'h0);
    load_coef(11, 32'h0);
    load_coef(15, 32'h0);
    send_vertex(32'h0002_0000, 32'hFFFE_0000, 32'h7FFF_FFFF);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
  endtask

  task automatic test_saturation();
    for (int i = 0; i < 16; i++)
      load_coef(i, (i % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // A tiny w makes the divide overflow.
    load_coef(15, 32'h0000_0001);
    load_coef(3, 32'h0);
    load_coef(7, 32'h0);
    load_coef(11, 32'h0);
    send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    load_coef(15, 32'hFFFF_FFFF);
    send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
  endtask

  task automatic test_view_extremes();
    set_view(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF);
    load_matrix(1'b0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_vertex(32'h0, 32'h0, 32'h0);
    set_view(16'h0, 16'h1, 16'h8000, 16'h7FFF, 32'h8000_0000);
    send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0010_0000);
    // Indices past the last register must be ignored.
    write_cfg(3'd5, 32'hFFFF_FFFF);
    write_cfg(3'd6, 32'h0);
    write_cfg(3'd7, 32'h1234_5678);
    send_vertex(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
  endtask

  task automatic test_random(input int n_items);
    int r;
    for (int k = 0; k < n_items; k++) begin
      if (k % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 3) load_matrix($urandom_range(0, 7) == 0);
      else if (r < 15) load_coef($urandom_range(0, 15), rand_word());
      else send_vertex(rand_word(), rand_word(), rand_word());
    end
    calm = 1'b0;
  endtask

  initial begin
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= vtv_pkg::CMD_LOAD;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= vtv_pkg::CFG_IMAGE_WIDTH;
    cfg_data_i      <= '0;
    rst_ni          <= 1'b0;
    half_w_q = 960;
    half_h_q = 540;
    off_x_q  = 0;
    off_y_q  = 0;
    dscale_q = 0;
    calm     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_identity();
    test_zero_w();
    test_saturation();
    test_view_extremes();

    set_view(16'd1920, 16'd1080, 16'd0, 16'd0, 32'h0);
    load_matrix(1'b0);
    test_random(260);
    set_view(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), rand_word());
    test_random(260);
    set_view(16'd641, 16'd479, 16'hFF00, 16'h0100, 32'h0000_8000);
    test_random(260);
    set_view(16'hFFFF, 16'h0, 16'h7FFF, 16'h8000, 32'h8000_0000);
    test_random(260);

    s_axis_tvalid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d vertex beats, %0d coefficient loads, %0d register writes",
             vertices_sent, loads_sent, cfg_writes);
    $display("checked %0d screen points with random stalls on both streams",
             points_checked);
    if (mismatches == 0) begin
      $display("vertex_transform_viewport regression: pass");
    end else begin
      $display("vertex_transform_viewport regression: fail");
    end
    $finish;
  end

endmodule
